// ===== src/h2d_pkg.sv =====
// shared types and constants for the http2 frame deframer
`timescale 1ns / 1ps
package h2d_pkg;

	localparam int PrefaceLength = 24;
	localparam int PrefacePosW = 5;

	localparam logic [2:0] KIND_SEND_SETTINGS = 3'd0;
	localparam logic [2:0] KIND_PREFACE_BAD   = 3'd1;
	localparam logic [2:0] KIND_SETTINGS_ACK  = 3'd2;
	localparam logic [2:0] KIND_TABLE_SIZE    = 3'd3;
	localparam logic [2:0] KIND_PING_ACK      = 3'd4;
	localparam logic [2:0] KIND_HEADER_BYTE   = 3'd5;
	localparam logic [2:0] KIND_DATA_BYTE     = 3'd6;
	localparam logic [2:0] KIND_FRAME_END     = 3'd7;

	localparam logic [7:0] FT_DATA     = 8'h00;
	localparam logic [7:0] FT_HEADERS  = 8'h01;
	localparam logic [7:0] FT_SETTINGS = 8'h04;
	localparam logic [7:0] FT_PING     = 8'h06;
	localparam logic [7:0] FT_CONT     = 8'h09;

	localparam logic [7:0] FL_END_STREAM  = 8'h01;
	localparam logic [7:0] FL_END_HEADERS = 8'h04;
	localparam logic [7:0] FL_PADDED      = 8'h08;
	localparam logic [7:0] FL_PRIORITY    = 8'h20;

	localparam int QueueDepth = 4;
	localparam int QueuePtrW = 2;

	typedef enum logic [1:0] {
		PH_PREFACE = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [30:0] stream_number;
		logic [7:0]  payload_byte;
		logic [63:0] word_value;
		logic        from_continuation;
		logic        is_data_frame;
		logic        headers_done;
		logic        stream_done;
		logic        last;
	} result_t;

	// up to two results per byte
	typedef struct packed {
		logic    v0;
		logic    v1;
		result_t r0;
		result_t r1;
	} pair_t;

	function automatic logic [7:0] preface_byte(input logic [PrefacePosW-1:0] idx);
		logic [7:0] b;
		case (idx)
			5'd0: b = 8'h50;
			5'd1: b = 8'h52;
			5'd2: b = 8'h49;
			5'd3: b = 8'h20;
			5'd4: b = 8'h2A;
			5'd5: b = 8'h20;
			5'd6: b = 8'h48;
			5'd7: b = 8'h54;
			5'd8: b = 8'h54;
			5'd9: b = 8'h50;
			5'd10: b = 8'h2F;
			5'd11: b = 8'h32;
			5'd12: b = 8'h2E;
			5'd13: b = 8'h30;
			5'd14: b = 8'h0D;
			5'd15: b = 8'h0A;
			5'd16: b = 8'h0D;
			5'd17: b = 8'h0A;
			5'd18: b = 8'h53;
			5'd19: b = 8'h4D;
			5'd20: b = 8'h0D;
			5'd21: b = 8'h0A;
			5'd22: b = 8'h0D;
			5'd23: b = 8'h0A;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ===== src/h2d_if.sv =====
// valid/ready channel interfaces for byte input and result output
`timescale 1ns / 1ps
interface h2d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface h2d_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [30:0] stream_number;
	logic [7:0]  payload_byte;
	logic [63:0] word_value;
	logic        from_continuation;
	logic        is_data_frame;
	logic        headers_done;
	logic        stream_done;
	logic        last;
	modport source (output valid, output kind, output stream_number, output payload_byte,
		output word_value, output from_continuation, output is_data_frame,
		output headers_done, output stream_done, output last, input ready);
	modport sink (input valid, input kind, input stream_number, input payload_byte,
		input word_value, input from_continuation, input is_data_frame,
		input headers_done, input stream_done, input last, output ready);
endinterface

// ===== src/h2d_parser.sv =====
// front end: preface match, frame header and payload parsing, one byte per cycle while step is high
`timescale 1ns / 1ps
module h2d_parser
	import h2d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] b,
	output pair_t      pair
);

	phase_t            phase_q;
	logic [PrefacePosW-1:0] pre_pos_q;
	logic              pre_bad_q;
	logic [47:0]       hdr_q;
	logic [23:0]       pos_q;
	logic [23:0]       cstart_q;
	logic [23:0]       len_q;
	logic              drop_q;
	logic [63:0]       coll_q;
	logic [2:0]        set_cnt_q;

	phase_t            phase_d;
	logic [PrefacePosW-1:0] pre_pos_d;
	logic              pre_bad_d;
	logic [47:0]       hdr_d;
	logic [23:0]       pos_d;
	logic [23:0]       cstart_d;
	logic [23:0]       len_d;
	logic              drop_d;
	logic [63:0]       coll_d;
	logic [2:0]        set_cnt_d;

	logic [7:0]  ft, ff;
	logic [30:0] sid;
	logic        bad_now;
	logic [23:0] pos_inc;
	logic        emit_a, emit_b;
	result_t     ra, rb, rz, rend;
	logic [24:0] pad_rem;
	logic [7:0]  nt, nf;
	logic [30:0] nsid;
	logic [23:0] nlen;
	logic        ndrop;

	// end-of-frame result for a given header
	function automatic result_t end_res(input logic [7:0] t, input logic [7:0] f,
		input logic [30:0] s, input logic [63:0] w);
		result_t r;
		r = '0;
		r.stream_number = s;
		case (t)
			FT_SETTINGS: r.kind = KIND_SETTINGS_ACK;
			FT_PING: begin
				r.kind = KIND_PING_ACK;
				r.word_value = w;
			end
			FT_HEADERS: begin
				r.kind = KIND_FRAME_END;
				r.headers_done = |(f & FL_END_HEADERS);
				r.stream_done = |(f & FL_END_STREAM);
			end
			FT_CONT: begin
				r.kind = KIND_FRAME_END;
				r.from_continuation = 1'b1;
				r.headers_done = |(f & FL_END_HEADERS);
			end
			default: begin
				r.kind = KIND_FRAME_END;
				r.is_data_frame = 1'b1;
				r.stream_done = |(f & FL_END_STREAM);
			end
		endcase
		return r;
	endfunction

	assign ft  = hdr_q[47:40];
	assign ff  = hdr_q[39:32];
	assign sid = hdr_q[30:0];
	assign pos_inc = pos_q + 24'd1;

	always_comb begin
		phase_d = phase_q;
		pre_pos_d = pre_pos_q;
		pre_bad_d = pre_bad_q;
		hdr_d = hdr_q;
		pos_d = pos_q;
		cstart_d = cstart_q;
		len_d = len_q;
		drop_d = drop_q;
		coll_d = coll_q;
		set_cnt_d = set_cnt_q;
		emit_a = 1'b0;
		emit_b = 1'b0;
		rz = '0;
		ra = '0;
		rb = '0;
		bad_now = 1'b0;
		pad_rem = '0;
		nt = '0;
		nf = '0;
		nsid = '0;
		nlen = '0;
		ndrop = 1'b0;
		rend = '0;
		unique case (phase_q)
			PH_PREFACE: begin
				bad_now = pre_bad_q | (b != preface_byte(pre_pos_q));
				if (32'(pre_pos_q) + 32'd1 >= 32'(PrefaceLength)) begin
					emit_a = 1'b1;
					ra = rz;
					ra.kind = bad_now ? KIND_PREFACE_BAD : KIND_SEND_SETTINGS;
					if (!bad_now) begin
						phase_d = PH_HEADER;
						pos_d = '0;
					end
					pre_pos_d = '0;
					pre_bad_d = 1'b0;
				end else begin
					pre_pos_d = pre_pos_q + 1'b1;
					pre_bad_d = bad_now;
				end
			end
			PH_HEADER: begin
				hdr_d = {hdr_q[39:0], b};
				if (pos_q < 24'd3) len_d = {len_q[15:0], b};
				pos_d = pos_inc;
				if (pos_q == 24'd8) begin
					pos_d = '0;
					phase_d = PH_PAYLOAD;
					nt = hdr_d[47:40];
					nf = hdr_d[39:32];
					nsid = hdr_d[30:0];
					nlen = len_d;
					cstart_d = '0;
					coll_d = {40'd0, nlen};
					set_cnt_d = '0;
					case (nt)
						FT_SETTINGS: begin
							coll_d = '0;
							ndrop = (nsid != '0) | nf[0];
						end
						FT_PING: begin
							coll_d = '0;
							ndrop = (nsid != '0) | nf[0] | (nlen != 24'd8);
						end
						FT_HEADERS: begin
							if (nsid == '0) ndrop = 1'b1;
							else if (|(nf & FL_PADDED)) ndrop = (nlen == '0);
							else if (|(nf & FL_PRIORITY)) begin
								if (nlen < 24'd5) ndrop = 1'b1;
								else cstart_d = 24'd5;
							end
						end
						FT_DATA: begin
							if (nsid == '0) ndrop = 1'b1;
							else if (|(nf & FL_PADDED) && nlen == '0) ndrop = 1'b1;
						end
						FT_CONT: ndrop = (nsid == '0);
						default: ndrop = 1'b1;
					endcase
					drop_d = ndrop;
					if (nlen == '0) begin
						phase_d = PH_HEADER;
						if (!ndrop) begin
							emit_a = 1'b1;
							ra = end_res(nt, nf, nsid, 64'd0);
						end
					end
				end
			end
			default: begin
				// payload byte
				ndrop = drop_q;
				if (!ndrop && (ft == FT_HEADERS || ft == FT_DATA) && |(ff & FL_PADDED)
					&& pos_q == '0) begin
					if (25'(len_q) < 25'd1 + 25'(b)) ndrop = 1'b1;
					else begin
						pad_rem = 25'(len_q) - 25'(b);
						coll_d = {39'd0, pad_rem};
						cstart_d = 24'd1;
						if (ft == FT_HEADERS && |(ff & FL_PRIORITY)) begin
							if (pad_rem < 25'd6) ndrop = 1'b1;
							else cstart_d = 24'd6;
						end
					end
				end
				drop_d = ndrop;
				if (!ndrop) begin
					if (ft == FT_HEADERS || ft == FT_CONT || ft == FT_DATA) begin
						if (pos_q >= cstart_d && 64'(pos_q) < coll_d) begin
							emit_a = 1'b1;
							ra = rz;
							ra.kind = (ft == FT_DATA) ? KIND_DATA_BYTE : KIND_HEADER_BYTE;
							ra.stream_number = sid;
							ra.payload_byte = b;
							ra.from_continuation = (ft == FT_CONT);
						end
					end else if (ft == FT_SETTINGS) begin
						coll_d = {coll_q[55:0], b};
						// six-byte entry counter replaces the modulo
						set_cnt_d = (set_cnt_q == 3'd5) ? 3'd0 : set_cnt_q + 3'd1;
						if (set_cnt_q == 3'd5 && coll_d[47:32] == 16'd1) begin
							emit_a = 1'b1;
							ra = rz;
							ra.kind = KIND_TABLE_SIZE;
							ra.stream_number = sid;
							ra.word_value = {32'd0, coll_d[31:0]};
						end
					end else if (ft == FT_PING) begin
						coll_d = {coll_q[55:0], b};
					end
				end
				pos_d = pos_inc;
				if (pos_inc >= len_q) begin
					phase_d = PH_HEADER;
					pos_d = '0;
					if (!ndrop && (ft == FT_SETTINGS || ft == FT_PING || ft == FT_HEADERS
						|| ft == FT_CONT || ft == FT_DATA)) begin
						rend = end_res(ft, ff, sid, coll_d);
						if (emit_a) begin
							emit_b = 1'b1;
							rb = rend;
						end else begin
							emit_a = 1'b1;
							ra = rend;
						end
					end
				end
			end
		endcase
		ra.last = emit_a & ~emit_b;
		rb.last = emit_b;
		pair.v0 = step & emit_a;
		pair.v1 = step & emit_b;
		pair.r0 = ra;
		pair.r1 = rb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PREFACE;
			pre_pos_q <= '0;
			pre_bad_q <= 1'b0;
			hdr_q <= '0;
			pos_q <= '0;
			cstart_q <= '0;
			len_q <= '0;
			drop_q <= 1'b0;
			coll_q <= '0;
			set_cnt_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pre_pos_q <= pre_pos_d;
			pre_bad_q <= pre_bad_d;
			hdr_q <= hdr_d;
			pos_q <= pos_d;
			cstart_q <= cstart_d;
			len_q <= len_d;
			drop_q <= drop_d;
			coll_q <= coll_d;
			set_cnt_q <= set_cnt_d;
		end
	end

endmodule

// ===== src/h2d_queue.sv =====
// result queue between the parser and the output port, up to two writes per cycle
`timescale 1ns / 1ps
module h2d_queue
	import h2d_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  pair_t   wr,
	output logic    has_room,
	output logic    rd_valid,
	output result_t rd_data,
	input  logic    rd_take
);

	result_t mem_q [QueueDepth];
	logic [QueuePtrW-1:0] wp_q, rp_q;
	logic [QueuePtrW:0]   cnt_q;
	logic [QueuePtrW-1:0] wp1;
	logic [1:0]           nwr;

	assign wp1 = wp_q + 1'b1;
	assign nwr = {1'b0, wr.v0} + {1'b0, wr.v1};
	assign has_room = cnt_q <= (QueuePtrW+1)'(QueueDepth - 2);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr.v0) mem_q[wp_q] <= wr.r0;
		if (wr.v1) mem_q[wp1] <= wr.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			wp_q <= wp_q + QueuePtrW'(nwr);
			if (rd_take && rd_valid) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (QueuePtrW+1)'(nwr)
				- (QueuePtrW+1)'(rd_take && rd_valid);
		end
	end

endmodule

// ===== src/http2_frame_deframer_core.sv =====
// top level of the http2 receive-side frame deframer
`timescale 1ns / 1ps
//  channel   dir  beat payload
//  rx        in   byte_in (one connection byte)
//  ev        out  kind, stream_number, payload_byte, word_value, flags, last
//
//  one byte per cycle while rx is not stalled; each byte gives zero, one or two
//  result beats, set by the parser's combinational next-state logic
//  results go to a four-entry queue read one beat per cycle at the output while ev.ready is high
//  rx stalls only while the queue has fewer than two free entries
//  arst_n puts the parser back in preface matching and empties the queue
module http2_frame_deframer_core
	import h2d_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	h2d_byte_if.sink     rx,
	h2d_result_if.source ev
);

	pair_t   pair;
	logic    room;
	logic    step;
	result_t head;

	// a byte steps the parser when the queue can take both possible results
	assign rx.ready = room;
	assign step = rx.valid & room;

	h2d_parser u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.b      (rx.byte_in),
		.pair   (pair)
	);

	h2d_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (pair),
		.has_room (room),
		.rd_valid (ev.valid),
		.rd_data  (head),
		.rd_take  (ev.ready)
	);

	// result beat fields straight from the queue head
	assign ev.kind = head.kind;
	assign ev.stream_number = head.stream_number;
	assign ev.payload_byte = head.payload_byte;
	assign ev.word_value = head.word_value;
	assign ev.from_continuation = head.from_continuation;
	assign ev.is_data_frame = head.is_data_frame;
	assign ev.headers_done = head.headers_done;
	assign ev.stream_done = head.stream_done;
	assign ev.last = head.last;

endmodule

// ===== tb/http2_frame_deframer_core_tb.sv =====
// self-checking testbench for the http2 frame deframer: directed table and frames, then random frames
`timescale 1ns / 1ps
module http2_frame_deframer_core_tb;
	import h2d_pkg::*;

	logic clk;
	logic arst_n;

	h2d_byte_if   rx ();
	h2d_result_if ev ();

	http2_frame_deframer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.ev     (ev)
	);

	// shadow parser state
	phase_t      sh_phase;
	int unsigned sh_pre_pos;
	bit          sh_pre_bad;
	bit [63:0]   sh_hdr;
	bit [23:0]   sh_pos;
	bit [23:0]   sh_cstart;
	bit [23:0]   sh_len;
	bit          sh_drop;
	bit [63:0]   sh_coll;

	result_t pending_events[$];
	result_t step_events[$];

	int errors;
	int mismatches;
	int checked;
	int bytes_sent;
	int frames_sent;
	longint cycles;
	int src_idle_pct;
	int snk_idle_pct;

	localparam longint CycleLimit = 400000;

	function automatic bit [7:0] expected_preface(int unsigned idx);
		// the known preface is 24 bytes, zeros past that
		bit [7:0] s [24] = '{8'h50, 8'h52, 8'h49, 8'h20, 8'h2A, 8'h20, 8'h48, 8'h54,
			8'h54, 8'h50, 8'h2F, 8'h32, 8'h2E, 8'h30, 8'h0D, 8'h0A,
			8'h0D, 8'h0A, 8'h53, 8'h4D, 8'h0D, 8'h0A, 8'h0D, 8'h0A};
		return (idx < 24) ? s[idx] : 8'h00;
	endfunction

	function automatic void push_event(bit [2:0] k, bit [30:0] sid, bit [7:0] pb,
			bit [63:0] w, bit cont, bit dat, bit eh, bit es);
		result_t r;
		r = '0;
		r.kind = k;
		r.stream_number = sid;
		r.payload_byte = pb;
		r.word_value = w;
		r.from_continuation = cont;
		r.is_data_frame = dat;
		r.headers_done = eh;
		r.stream_done = es;
		step_events.insert(step_events.size(), r);
	endfunction

	function automatic bit [7:0] cur_type();
		return sh_hdr[47:40];
	endfunction

	function automatic bit [7:0] cur_flags();
		return sh_hdr[39:32];
	endfunction

	function automatic bit [30:0] cur_sid();
		return sh_hdr[30:0];
	endfunction

	// decide after the ninth header byte whether the frame is kept
	function automatic void open_frame();
		bit [7:0] t;
		bit [7:0] f;
		t = cur_type();
		f = cur_flags();
		sh_drop = 0;
		sh_cstart = 0;
		sh_coll = 64'(sh_len);
		if (t == FT_SETTINGS) begin
			sh_coll = 0;
			sh_drop = (cur_sid() != 0) || (f & FL_END_STREAM) != 0;
		end else if (t == FT_PING) begin
			sh_coll = 0;
			sh_drop = (cur_sid() != 0) || (f & FL_END_STREAM) != 0 || sh_len != 8;
		end else if (t == FT_HEADERS) begin
			if (cur_sid() == 0)
				sh_drop = 1;
			else if (f & FL_PADDED) begin
				if (sh_len < 1)
					sh_drop = 1;
			end else if (f & FL_PRIORITY) begin
				if (sh_len < 5)
					sh_drop = 1;
				else
					sh_cstart = 5;
			end
		end else if (t == FT_DATA) begin
			if (cur_sid() == 0)
				sh_drop = 1;
			else if ((f & FL_PADDED) && sh_len < 1)
				sh_drop = 1;
		end else if (t == FT_CONT) begin
			if (cur_sid() == 0)
				sh_drop = 1;
		end else begin
			sh_drop = 1;
		end
	endfunction

	function automatic void close_frame();
		bit [7:0] t;
		bit [7:0] f;
		t = cur_type();
		f = cur_flags();
		if (!sh_drop) begin
			if (t == FT_SETTINGS)
				push_event(KIND_SETTINGS_ACK, cur_sid(), 0, 0, 0, 0, 0, 0);
			else if (t == FT_PING)
				push_event(KIND_PING_ACK, cur_sid(), 0, sh_coll, 0, 0, 0, 0);
			else if (t == FT_HEADERS)
				push_event(KIND_FRAME_END, cur_sid(), 0, 0, 0, 0, f[2], f[0]);
			else if (t == FT_CONT)
				push_event(KIND_FRAME_END, cur_sid(), 0, 0, 1, 0, f[2], 0);
			else if (t == FT_DATA)
				push_event(KIND_FRAME_END, cur_sid(), 0, 0, 0, 1, 0, f[0]);
		end
		sh_phase = PH_HEADER;
		sh_pos = 0;
	endfunction

	function automatic void payload_step(bit [7:0] b);
		bit [7:0] t;
		bit [7:0] f;
		bit [23:0] p;
		t = cur_type();
		f = cur_flags();
		p = sh_pos;
		if (!sh_drop && (t == FT_HEADERS || t == FT_DATA) && (f & FL_PADDED) && p == 0) begin
			if (32'(sh_len) < 32'(b) + 1) begin
				sh_drop = 1;
			end else begin
				sh_coll = 64'(sh_len - 24'(b));
				sh_cstart = 1;
				if (t == FT_HEADERS && (f & FL_PRIORITY)) begin
					if (sh_coll < 6)
						sh_drop = 1;
					else
						sh_cstart = 6;
				end
			end
		end
		if (!sh_drop) begin
			if (t == FT_HEADERS || t == FT_CONT || t == FT_DATA) begin
				if (p >= sh_cstart && 64'(p) < sh_coll)
					push_event(t == FT_DATA ? KIND_DATA_BYTE : KIND_HEADER_BYTE, cur_sid(),
						b, 0, t == FT_CONT, 0, 0, 0);
			end else if (t == FT_SETTINGS) begin
				sh_coll = {sh_coll[55:0], b};
				if ((32'(p) + 1) % 6 == 0 && sh_coll[47:32] == 16'd1)
					push_event(KIND_TABLE_SIZE, cur_sid(), 0, {32'd0, sh_coll[31:0]}, 0, 0, 0, 0);
			end else if (t == FT_PING) begin
				sh_coll = {sh_coll[55:0], b};
			end
		end
		sh_pos = p + 1;
		if (32'(p) + 1 >= 32'(sh_len))
			close_frame();
	endfunction

	// advance the shadow parser by one byte and queue what it should emit
	function automatic void predict_byte(bit [7:0] b);
		step_events.delete();
		if (sh_phase == PH_PREFACE) begin
			if (b != expected_preface(sh_pre_pos))
				sh_pre_bad = 1;
			if (sh_pre_pos + 1 >= PrefaceLength) begin
				push_event(sh_pre_bad ? KIND_PREFACE_BAD : KIND_SEND_SETTINGS, 0, 0, 0, 0, 0, 0, 0);
				if (!sh_pre_bad) begin
					sh_phase = PH_HEADER;
					sh_pos = 0;
				end
				sh_pre_pos = 0;
				sh_pre_bad = 0;
			end else begin
				sh_pre_pos = (sh_pre_pos + 1) % 32;
			end
		end else if (sh_phase == PH_PAYLOAD) begin
			payload_step(b);
		end else begin
			sh_hdr = {sh_hdr[55:0], b};
			if (sh_pos < 3)
				sh_len = {sh_len[15:0], b};
			sh_pos = sh_pos + 1;
			if (sh_pos >= 9) begin
				sh_pos = 0;
				sh_phase = PH_PAYLOAD;
				open_frame();
				if (sh_len == 0)
					close_frame();
			end
		end
		if (step_events.size() > 0)
			step_events[step_events.size() - 1].last = 1;
		foreach (step_events[i])
			pending_events.insert(pending_events.size(), step_events[i]);
	endfunction

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// cycle counter and watchdog
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CycleLimit) begin
				$display("timeout after %0d cycles, %0d events outstanding",
					cycles, pending_events.size());
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// receiver: random ready at the falling edge, compare at the rising edge
	initial begin
		ev.ready = 0;
		forever begin
			@(negedge clk);
			ev.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && ev.valid && ev.ready) begin
			got.kind = ev.kind;
			got.stream_number = ev.stream_number;
			got.payload_byte = ev.payload_byte;
			got.word_value = ev.word_value;
			got.from_continuation = ev.from_continuation;
			got.is_data_frame = ev.is_data_frame;
			got.headers_done = ev.headers_done;
			got.stream_done = ev.stream_done;
			got.last = ev.last;
			if (pending_events.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected event beat kind %0d at cycle %0d", got.kind, cycles);
			end else begin
				want = pending_events.pop_front();
				checked++;
				if (got !== want) begin
					errors++;
					mismatches++;
					if (mismatches <= 10) begin
						$display("event mismatch at cycle %0d", cycles);
						$display("  expected kind %0d sid %h byte %h word %h c%0b d%0b eh%0b es%0b last%0b",
							want.kind, want.stream_number, want.payload_byte, want.word_value,
							want.from_continuation, want.is_data_frame, want.headers_done,
							want.stream_done, want.last);
						$display("  actual   kind %0d sid %h byte %h word %h c%0b d%0b eh%0b es%0b last%0b",
							got.kind, got.stream_number, got.payload_byte, got.word_value,
							got.from_continuation, got.is_data_frame, got.headers_done,
							got.stream_done, got.last);
					end
				end
			end
		end
	end

	// send one byte; prediction happens on acceptance, valid stays up for the next byte
	task automatic send_byte(input bit [7:0] b);
		while ($urandom_range(99) < src_idle_pct) begin
			rx.valid <= 0;
			@(negedge clk);
		end
		rx.valid <= 1;
		rx.byte_in <= b;
		@(posedge clk);
		while (!rx.ready)
			@(posedge clk);
		predict_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_header(input bit [23:0] len, input bit [7:0] t, input bit [7:0] f,
			input bit [31:0] sid);
		send_byte(len[23:16]);
		send_byte(len[15:8]);
		send_byte(len[7:0]);
		send_byte(t);
		send_byte(f);
		send_byte(sid[31:24]);
		send_byte(sid[23:16]);
		send_byte(sid[15:8]);
		send_byte(sid[7:0]);
		frames_sent++;
	endtask

	// one random frame; mostly well formed, some broken or unknown
	task automatic send_random_frame();
		bit [7:0] t;
		bit [7:0] f;
		bit [31:0] sid;
		bit [23:0] len;
		int sel;
		int pad;
		sel = $urandom_range(99);
		f = 8'($urandom);
		sid = {1'($urandom), 31'($urandom_range(7, 1))};
		if ($urandom_range(15) == 0)
			sid = $urandom;
		len = 24'($urandom_range(12));
		if (sel < 15) begin
			t = FT_SETTINGS;
			sid = ($urandom_range(9) == 0) ? 32'd3 : 32'd0;
			f[0] = ($urandom_range(9) == 0);
			len = 24'(6 * $urandom_range(3) + (($urandom_range(5) == 0) ? $urandom_range(5) : 0));
		end else if (sel < 27) begin
			t = FT_PING;
			sid = ($urandom_range(9) == 0) ? 32'h8000_0001 : {1'($urandom), 31'd0};
			f[0] = ($urandom_range(9) == 0);
			len = ($urandom_range(9) == 0) ? 24'($urandom_range(9)) : 24'd8;
		end else if (sel < 50) begin
			t = FT_HEADERS;
		end else if (sel < 65) begin
			t = FT_CONT;
		end else if (sel < 90) begin
			t = FT_DATA;
		end else begin
			t = 8'($urandom);
		end
		if ($urandom_range(19) == 0)
			sid[30:0] = 0;
		send_header(len, t, f, sid);
		pad = $urandom_range(len + 2);
		for (int i = 0; i < len; i++) begin
			if (t == FT_SETTINGS && i % 6 == 1 && $urandom_range(1))
				send_byte(8'd1);
			else if (t == FT_SETTINGS && i % 6 == 0)
				send_byte($urandom_range(3) == 0 ? 8'($urandom) : 8'd0);
			else if (i == 0 && f[3] && (t == FT_HEADERS || t == FT_DATA))
				send_byte(8'(pad));
			else
				send_byte(8'($urandom));
		end
	endtask

	typedef struct {
		bit [7:0]  b;
		bit        has_want;
		bit [2:0]  kind;
	} stim_row_t;

	// directed stream: bad preface, good preface, empty frames, extremes
	stim_row_t stim_rows[$];

	task automatic add_row(input bit [7:0] b, input bit want = 0, input bit [2:0] k = 3'd0);
		stim_row_t row;
		row.b = b;
		row.has_want = want;
		row.kind = k;
		stim_rows.insert(stim_rows.size(), row);
	endtask

	initial begin
		int base;
		errors = 0;
		mismatches = 0;
		checked = 0;
		bytes_sent = 0;
		frames_sent = 0;
		src_idle_pct = 32;
		snk_idle_pct = 57;
		sh_phase = PH_PREFACE;
		sh_pre_pos = 0;
		sh_pre_bad = 0;
		sh_hdr = 0;
		sh_pos = 0;
		sh_cstart = 0;
		sh_len = 0;
		sh_drop = 0;
		sh_coll = 0;
		rx.valid = 0;
		rx.byte_in = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// preface with every byte at 0xff: every byte mismatches, typed in below
		for (int i = 0; i < PrefaceLength; i++)
			add_row(8'hFF, i == PrefaceLength - 1, KIND_PREFACE_BAD);
		for (int i = 0; i < PrefaceLength; i++)
			add_row(expected_preface(i), i == PrefaceLength - 1, KIND_SEND_SETTINGS);
		// empty settings frame: ack given with the last header byte
		for (int i = 0; i < 8; i++)
			add_row(i == 3 ? FT_SETTINGS : 8'h00);
		add_row(8'h00, 1, KIND_SETTINGS_ACK);
		// empty headers on the highest stream, both end flags set: frame end
		add_row(0); add_row(0); add_row(0); add_row(FT_HEADERS); add_row(8'h05);
		add_row(8'hFF); add_row(8'hFF); add_row(8'hFF);
		add_row(8'hFF, 1, KIND_FRAME_END);

		foreach (stim_rows[i]) begin
			send_byte(stim_rows[i].b);
			if (stim_rows[i].has_want && (step_events.size() == 0
					|| step_events[step_events.size() - 1].kind != stim_rows[i].kind)) begin
				errors++;
				$display("directed row %0d: shadow parser disagrees on event kind %0d",
					i, stim_rows[i].kind);
			end
		end

		// directed frames: padded data, priority headers, continuation, ping, table size
		send_header(24'd6, FT_DATA, FL_PADDED | FL_END_STREAM, 32'd5);
		send_byte(8'd2); send_byte(8'h00); send_byte(8'hFF); send_byte(8'h11); send_byte(8'h22);
		send_byte(8'h33);
		send_header(24'd7, FT_HEADERS, FL_PRIORITY, 32'h7FFF_FFFF);
		for (int i = 0; i < 7; i++) send_byte(8'(i * 37));
		send_header(24'd2, FT_CONT, FL_END_HEADERS, 32'h7FFF_FFFF);
		send_byte(8'hAA); send_byte(8'h55);
		send_header(24'd8, FT_PING, 8'h00, 32'd0);
		for (int i = 0; i < 8; i++) send_byte(8'hF0 + 8'(i));
		send_header(24'd6, FT_SETTINGS, 8'h00, 32'd0);
		send_byte(0); send_byte(1); send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);
		send_byte(8'hFF);
		// padding longer than the payload, then an unknown type
		send_header(24'd2, FT_DATA, FL_PADDED, 32'd1);
		send_byte(8'd9); send_byte(8'h01);
		send_header(24'd1, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
		send_byte(8'h00);

		// random part in three idling regimes
		for (int phase_no = 0; phase_no < 3; phase_no++) begin
			src_idle_pct = (phase_no == 0) ? 32 : (phase_no == 1) ? 57 : 0;
			snk_idle_pct = (phase_no == 0) ? 57 : (phase_no == 1) ? 32 : 0;
			base = bytes_sent;
			while (bytes_sent - base < 125) begin
				// occasionally a fresh reset-free restart is impossible, so only
				// frame-level noise is injected here
				if ($urandom_range(24) == 0)
					send_byte(8'($urandom));
				else
					send_random_frame();
			end
		end
		rx.valid <= 0;

		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("sent %0d bytes in %0d frames plus preface, checked %0d event beats",
			bytes_sent, frames_sent, checked);
		$display("covered preface mismatch and match, settings, ping, headers, data, continuation");
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
